FILE: rtl/circular_list_cursor_engine_assert.svh
// assertion macros for the list cursor engine checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef CIRCULAR_LIST_CURSOR_ENGINE_ASSERT_SVH
`define CIRCULAR_LIST_CURSOR_ENGINE_ASSERT_SVH

// same-cycle implication, masked during reset
`define CLCE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define CLCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/clce_pkg.sv
// shared types and constants for the list cursor engine
// no dependencies
`timescale 1ns / 1ps

package clce_pkg;

    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned COUNT_FIELD_W = 5;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_DELETE = 3'd1,
        OP_WRITE  = 3'd2,
        OP_READ   = 3'd3,
        OP_NEXT   = 3'd4,
        OP_BACK   = 3'd5,
        OP_FIRST  = 3'd6,
        OP_LAST   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                        operation;
        logic signed [VALUE_W-1:0]  write_value;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        t_status                    status;
        logic [COUNT_FIELD_W-1:0]   node_count;
    } t_out_beat;

    typedef struct packed {
        logic we;
        logic zero_fill;
    } t_val_ctl;

endpackage

FILE: rtl/circular_list_cursor_engine.sv
// top level of the circular list cursor engine: input register, list core, value store,
// result register; depends on clce_pkg, clce_list_core and clce_value_store
//
//   channel   direction   handshake           beat
//   input     in          i_valid / o_stall   i_beat  (t_in_beat)
//   result    out         o_valid / i_stall   o_beat  (t_out_beat)
//
// one beat per cycle sustained unless the result side stalls; from input acceptance to
// result valid: input register, then result register, with the list update between them
// reset clears slot usage, head, tail, cursor, count and both valids; link and value
// storage stay uninitialised and need no clearing pass
// o_stall rises only when both registers hold a beat and the result side stalls
`timescale 1ns / 1ps

module circular_list_cursor_engine
    import clce_pkg::*;
#(
    parameter int POOL_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_beat,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_beat
);

    localparam int SW = $clog2(POOL_DEPTH);

    logic      r_in_valid;
    t_in_beat  r_in_beat;
    logic      r_out_valid;
    t_out_beat r_out_beat;

    logic                      fire;
    t_out_beat                 result;
    t_val_ctl                  val_ctl;
    logic [SW-1:0]             val_waddr;
    logic [SW-1:0]             val_raddr;
    logic signed [VALUE_W-1:0] cur_value;

    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;
    assign o_valid = r_out_valid;
    assign o_beat  = r_out_beat;

    clce_list_core #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_list_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_beat      (r_in_beat),
        .i_cur_value (cur_value),
        .o_result    (result),
        .o_val_ctl   (val_ctl),
        .o_waddr     (val_waddr),
        .o_raddr     (val_raddr)
    );

    clce_value_store #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_value_store (
        .i_clk   (i_clk),
        .i_ctl   (val_ctl),
        .i_waddr (val_waddr),
        .i_wdata (r_in_beat.write_value),
        .i_raddr (val_raddr),
        .o_rdata (cur_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_beat <= i_beat;
        end
        if (fire) begin
            r_out_beat <= result;
        end
    end

endmodule

FILE: rtl/clce_free_find.sv
// lowest free slot finder over the slot-used vector
// depends on nothing but its parameter
`timescale 1ns / 1ps

module clce_free_find #(
    parameter  int POOL_DEPTH = 16,
    localparam int SW         = $clog2(POOL_DEPTH)
) (
    input  logic [POOL_DEPTH-1:0] i_used,
    output logic [SW-1:0]         o_slot,
    output logic                  o_found
);

    always_comb begin
        o_slot  = '0;
        o_found = 1'b0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_slot  = SW'(i);
                o_found = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/clce_value_store.sv
// node value memory with a registered read port that follows the cursor
// depends on clce_pkg
`timescale 1ns / 1ps

module clce_value_store
    import clce_pkg::*;
#(
    parameter  int POOL_DEPTH = 16,
    localparam int SW         = $clog2(POOL_DEPTH)
) (
    input  logic                      i_clk,
    input  t_val_ctl                  i_ctl,
    input  logic [SW-1:0]             i_waddr,
    input  logic signed [VALUE_W-1:0] i_wdata,
    input  logic [SW-1:0]             i_raddr,
    output logic signed [VALUE_W-1:0] o_rdata
);

    logic signed [VALUE_W-1:0] r_mem [POOL_DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;
    logic signed [VALUE_W-1:0] n_wdata;

    assign n_wdata = i_ctl.zero_fill ? '0 : i_wdata;
    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= n_wdata;
        end
    end

    // write-through so the cursor value is current on the next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.we && (i_waddr == i_raddr)) begin
            r_rdata <= n_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/clce_list_core.sv
// list state: links, slot usage, head, tail, cursor and count, plus the per-beat update
// depends on clce_pkg and clce_free_find
`timescale 1ns / 1ps

module clce_list_core
    import clce_pkg::*;
#(
    parameter  int POOL_DEPTH = 16,
    localparam int SW         = $clog2(POOL_DEPTH),
    localparam int CW         = $clog2(POOL_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  t_in_beat                  i_beat,
    input  logic signed [VALUE_W-1:0] i_cur_value,
    output t_out_beat                 o_result,
    output t_val_ctl                  o_val_ctl,
    output logic [SW-1:0]             o_waddr,
    output logic [SW-1:0]             o_raddr
);

    localparam int CXW = (CW > COUNT_FIELD_W) ? CW : COUNT_FIELD_W;

    logic [POOL_DEPTH-1:0] r_used;
    logic [SW-1:0]         r_head;
    logic [SW-1:0]         r_tail;
    logic [SW-1:0]         r_cursor;
    logic [CW-1:0]         r_count;
    logic [SW-1:0]         r_next_link [POOL_DEPTH];
    logic [SW-1:0]         r_prev_link [POOL_DEPTH];

    logic [POOL_DEPTH-1:0] n_used;
    logic [SW-1:0]         n_head;
    logic [SW-1:0]         n_tail;
    logic [SW-1:0]         n_cursor;
    logic [CW-1:0]         n_count;

    logic [SW-1:0]         free_slot;
    logic                  free_found;
    logic [SW-1:0]         nl_c;
    logic [SW-1:0]         pl_c;
    logic                  empty;
    logic                  single;
    logic [CXW-1:0]        count_ext;
    t_status               status;
    logic signed [VALUE_W-1:0] rd_value;
    t_val_ctl              val_ctl;

    // two link write ports per direction
    logic                  nx_we_a, nx_we_b, pv_we_a, pv_we_b;
    logic [SW-1:0]         nx_wa_a, nx_wa_b, pv_wa_a, pv_wa_b;
    logic [SW-1:0]         nx_wd_a, nx_wd_b, pv_wd_a, pv_wd_b;

    clce_free_find #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_free_find (
        .i_used  (r_used),
        .o_slot  (free_slot),
        .o_found (free_found)
    );

    assign nl_c   = r_next_link[r_cursor];
    assign pl_c   = r_prev_link[r_cursor];
    assign empty  = (r_count == '0);
    assign single = (r_count == CW'(1));

    always_comb begin
        n_used   = r_used;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cursor = r_cursor;
        n_count  = r_count;
        status   = ST_DONE;
        rd_value = '0;
        val_ctl  = '0;
        o_waddr  = r_cursor;
        nx_we_a  = 1'b0;
        nx_we_b  = 1'b0;
        pv_we_a  = 1'b0;
        pv_we_b  = 1'b0;
        nx_wa_a  = free_slot;
        nx_wd_a  = free_slot;
        pv_wa_a  = free_slot;
        pv_wd_a  = free_slot;
        nx_wa_b  = r_tail;
        nx_wd_b  = free_slot;
        pv_wa_b  = r_head;
        pv_wd_b  = free_slot;

        if (i_beat.operation == OP_APPEND) begin
            if (!free_found) begin
                status = ST_FULL;
            end else begin
                n_used[free_slot] = 1'b1;
                val_ctl.we        = 1'b1;
                val_ctl.zero_fill = 1'b1;
                o_waddr           = free_slot;
                n_count           = r_count + CW'(1);
                nx_we_a           = 1'b1;
                pv_we_a           = 1'b1;
                if (empty) begin
                    n_head   = free_slot;
                    n_tail   = free_slot;
                    n_cursor = free_slot;
                end else begin
                    nx_wd_a = r_head;
                    pv_wd_a = r_tail;
                    nx_we_b = 1'b1;
                    pv_we_b = 1'b1;
                    n_tail  = free_slot;
                end
            end
        end else if (empty) begin
            status = ST_EMPTY;
        end else begin
            case (i_beat.operation)
                OP_DELETE: begin
                    n_used[r_cursor] = 1'b0;
                    if (single) begin
                        n_head   = '0;
                        n_tail   = '0;
                        n_cursor = '0;
                        n_count  = '0;
                    end else begin
                        nx_we_a = 1'b1;
                        nx_wa_a = pl_c;
                        nx_wd_a = nl_c;
                        pv_we_a = 1'b1;
                        pv_wa_a = nl_c;
                        pv_wd_a = pl_c;
                        if (r_head == r_cursor) begin
                            n_head = nl_c;
                        end
                        if (r_tail == r_cursor) begin
                            n_tail = pl_c;
                        end
                        n_cursor = pl_c;
                        n_count  = r_count - CW'(1);
                    end
                end
                OP_WRITE: begin
                    val_ctl.we = 1'b1;
                end
                OP_READ: begin
                    rd_value = i_cur_value;
                end
                OP_NEXT: begin
                    n_cursor = nl_c;
                end
                OP_BACK: begin
                    n_cursor = pl_c;
                end
                OP_FIRST: begin
                    n_cursor = r_head;
                end
                OP_LAST: begin
                    n_cursor = r_tail;
                end
                default: begin
                    n_cursor = r_cursor;
                end
            endcase
        end
    end

    assign count_ext           = CXW'(n_count);
    assign o_result.read_value = rd_value;
    assign o_result.status     = status;
    assign o_result.node_count = count_ext[COUNT_FIELD_W-1:0];
    assign o_val_ctl.we        = val_ctl.we & i_fire;
    assign o_val_ctl.zero_fill = val_ctl.zero_fill;
    assign o_raddr             = i_fire ? n_cursor : r_cursor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_cursor <= '0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_used   <= n_used;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cursor <= n_cursor;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (nx_we_a) begin
                r_next_link[nx_wa_a] <= nx_wd_a;
            end
            if (nx_we_b) begin
                r_next_link[nx_wa_b] <= nx_wd_b;
            end
            if (pv_we_a) begin
                r_prev_link[pv_wa_a] <= pv_wd_a;
            end
            if (pv_we_b) begin
                r_prev_link[pv_wa_b] <= pv_wd_b;
            end
        end
    end

endmodule

FILE: rtl/clce_checker.sv
// port-level checker for the list cursor engine, bound to the top level
// depends on clce_pkg and circular_list_cursor_engine_assert.svh
`timescale 1ns / 1ps

`include "circular_list_cursor_engine_assert.svh"

module clce_checker
    import clce_pkg::*;
#(
    parameter int POOL_DEPTH = 16
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_beat  i_beat,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_beat o_beat
);

    localparam logic [COUNT_FIELD_W-1:0] FULL_COUNT = COUNT_FIELD_W'(POOL_DEPTH);

    // stalled input beat holds
    `CLCE_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable(i_beat),
        "input beat changed while stalled")

    // stalled result beat holds
    `CLCE_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_beat),
        "result beat changed while stalled")

    // only a completed read carries data
    `CLCE_ASSERT_IMPL(a_rd_zero, o_valid && (o_beat.status != ST_DONE),
        o_beat.read_value == '0, "read value set on a failed operation")

    // empty status only with no nodes
    `CLCE_ASSERT_IMPL(a_empty_cnt, o_valid && (o_beat.status == ST_EMPTY),
        o_beat.node_count == '0, "empty status with nodes present")

    // full status only with the pool exhausted
    `CLCE_ASSERT_IMPL(a_full_cnt, o_valid && (o_beat.status == ST_FULL),
        o_beat.node_count == FULL_COUNT, "full status below pool depth")

endmodule

bind circular_list_cursor_engine clce_checker #(
    .POOL_DEPTH (POOL_DEPTH)
) u_clce_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_beat  (i_beat),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_beat  (o_beat)
);
